// ----- rtl/tbhv_pkg.sv -----
// Shared types, codes and constants for the take-back-half velocity controller.
package tbhv_pkg;

    // Field widths of the streaming payload and the configuration registers.
    localparam int ActW    = 2;
    localparam int MeasW   = 11;
    localparam int TgtW    = 10;
    localparam int CmdW    = 7;
    localparam int ErrW    = 12;
    localparam int DriveW  = 17;
    localparam int GainW   = 16;
    localparam int StepW   = 9;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    // Shared multiplier operand and product widths.
    localparam int MulAW = 18;
    localparam int MulBW = 17;
    localparam int MulPW = MulAW + MulBW;

    // Drive full scale, command ceiling and rounding constant.
    localparam logic [DriveW-1:0] DRIVE_FULL = 17'd65536;
    localparam logic [CmdW-1:0]   CMD_LIMIT  = 7'd127;
    localparam logic [MulPW-1:0]  CMD_ROUND  = 35'd32768;

    // Register reset values.
    localparam logic [GainW-1:0] GAIN_RST  = 16'd5033;
    localparam logic [StepW-1:0] ACCEL_RST = 9'd4;
    localparam logic [StepW-1:0] DECEL_RST = 9'd256;

    // Command codes carried in the input tuser.
    typedef enum logic [ActW-1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_STOP = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN  = 2'd0,
        CFG_ACCEL = 2'd1,
        CFG_DECEL = 2'd2,
        CFG_SPARE = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_ADD  = 5'b00100,
        S_MUL2 = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Sign of an error value: 01 positive, 11 negative, 00 zero.
    function automatic logic [1:0] sign_of(input logic signed [ErrW-1:0] v);
        logic [1:0] s;
        if (v == '0) begin
            s = 2'b00;
        end else if (v[ErrW-1]) begin
            s = 2'b11;
        end else begin
            s = 2'b01;
        end
        return s;
    endfunction

endpackage

// ----- rtl/tbh_velocity_control_with_slew_core.sv -----
// Top level: take-back-half velocity loop with slew-limited motor command.
// A control tick with the loop running steps through S_MUL1, S_ADD, S_MUL2 and S_OUT,
// waiting in S_OUT on a stalled output, before its result is registered; set target,
// stop, idle ticks and unused codes load the result register on acceptance. The single
// shared multiplier forms error*gain, then drive*MAX_POWER; input is held off while a tick runs.
// Synchronous active-low reset restores registers and clears loop state except r_err and r_meas.
module tbh_velocity_control_with_slew_core #(
    parameter int MAX_POWER = 127
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [23:0]                   i_s_axis_tdata,  // measured_rpm[10:0], target_rpm[20:11]
    input  logic [tbhv_pkg::ActW-1:0]     i_s_axis_tuser,  // action[1:0]
    // Output stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // motor_command[6:0]
    output logic [1:0]                    o_m_axis_tuser,  // zero_crossed[0], running[1]
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [tbhv_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tbhv_pkg::CfgW-1:0]     i_cfg_data
);
    import tbhv_pkg::*;

    // Configuration registers.
    logic [GainW-1:0] r_gain;
    logic [StepW-1:0] r_accel;
    logic [StepW-1:0] r_decel;

    // Loop state.
    t_state                   r_state;
    logic [TgtW-1:0]          r_target;
    logic signed [MeasW-1:0]  r_last_meas;
    logic [DriveW-1:0]        r_drive;
    logic [DriveW-1:0]        r_held;
    logic signed [ErrW-1:0]   r_prev_err;
    logic                     r_first;
    logic                     r_enabled;
    logic [CmdW-1:0]          r_slew;
    logic signed [ErrW-1:0]   r_err;
    logic signed [MeasW-1:0]  r_meas;
    logic                     r_crossed;

    // Output register.
    logic            r_out_valid;
    logic [CmdW-1:0] r_out_cmd;
    logic            r_out_cross;
    logic            r_out_run;

    // Input field decode.
    t_action                  in_act;
    logic signed [MeasW-1:0]  in_meas;
    logic [TgtW-1:0]          in_tgt;
    logic                     in_fire;
    logic                     out_free;
    logic                     out_load;

    assign in_act  = t_action'(i_s_axis_tuser);
    assign in_meas = $signed(i_s_axis_tdata[MeasW-1:0]);
    assign in_tgt  = i_s_axis_tdata[MeasW +: TgtW];

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // A result is loaded by every accepted command except a running tick, which
    // loads its result when the sequencer leaves the output state.
    assign out_load = (in_fire && !((in_act == ACT_TICK) && r_enabled))
                    || ((r_state == S_OUT) && out_free);

    // Shared multiplier operand selection.
    logic                    mul_en;
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [MulPW-1:0] mul_p;

    always_comb begin
        mul_en = (r_state == S_MUL1) || (r_state == S_MUL2);
        if (r_state == S_MUL1) begin
            mul_a = MulAW'(r_err);
            mul_b = $signed({1'b0, r_gain});
        end else begin
            mul_a = $signed({1'b0, r_drive});
            mul_b = MulBW'(MAX_POWER);
        end
    end

    tbhv_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Error for a new tick and for a new target.
    logic signed [ErrW-1:0] tick_err;
    logic signed [ErrW-1:0] set_err;

    assign tick_err = $signed({2'b00, r_target}) - ErrW'(in_meas);
    assign set_err  = $signed({2'b00, in_tgt}) - ErrW'(r_last_meas);

    // Drive integration, clamping and the take-back-half step.
    localparam int SumW = MulPW - 8 + 1;

    logic signed [SumW-1:0]  add_sum;
    logic [DriveW-1:0]       clamp_drive;
    logic                    add_cross;
    logic [DriveW:0]         avg_sum;
    logic [DriveW-1:0]       n_drive;

    always_comb begin
        add_sum = $signed({{(SumW-DriveW){1'b0}}, r_drive})
                + SumW'($signed(mul_p[MulPW-1:8]));
        if (add_sum[SumW-1]) begin
            clamp_drive = '0;
        end else if (add_sum > $signed({{(SumW-DriveW){1'b0}}, DRIVE_FULL})) begin
            clamp_drive = DRIVE_FULL;
        end else begin
            clamp_drive = add_sum[DriveW-1:0];
        end
        add_cross = sign_of(r_err) != sign_of(r_prev_err);
        avg_sum   = {1'b0, clamp_drive} + {1'b0, r_held};
        if (add_cross && !r_first) begin
            n_drive = avg_sum[DriveW:1];
        end else begin
            n_drive = clamp_drive;
        end
    end

    // Command scaling and slew limiting.
    logic [MulPW-1:0] cmd_sum;
    logic [CmdW-1:0]  cmd_tgt;
    logic [StepW-1:0] slew_step;
    logic [StepW:0]   slew_hi;
    logic [StepW:0]   tgt_hi;
    logic [CmdW-1:0]  n_slew;

    always_comb begin
        cmd_sum = $unsigned(mul_p) + CMD_ROUND;
        if (cmd_sum[MulPW-1:16] > (MulPW-16)'(CMD_LIMIT)) begin
            cmd_tgt = CMD_LIMIT;
        end else begin
            cmd_tgt = cmd_sum[16 +: CmdW];
        end
        slew_step = (r_slew < cmd_tgt) ? r_accel : r_decel;
        slew_hi   = {{(StepW+1-CmdW){1'b0}}, r_slew} + {1'b0, slew_step};
        tgt_hi    = {{(StepW+1-CmdW){1'b0}}, cmd_tgt} + {1'b0, slew_step};
        if ({{(StepW+1-CmdW){1'b0}}, cmd_tgt} > slew_hi) begin
            n_slew = slew_hi[CmdW-1:0];
        end else if ({{(StepW+1-CmdW){1'b0}}, r_slew} > tgt_hi) begin
            n_slew = r_slew - slew_step[CmdW-1:0];
        end else begin
            n_slew = cmd_tgt;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_accel <= ACCEL_RST;
            r_decel <= DECEL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:  r_gain  <= i_cfg_data;
                CFG_ACCEL: r_accel <= i_cfg_data[StepW-1:0];
                CFG_DECEL: r_decel <= i_cfg_data[StepW-1:0];
                CFG_SPARE: ;
                default:   ;
            endcase
        end
    end

    // Result valid flag: set on a load, cleared when the transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer and loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_last_meas <= '0;
            r_drive     <= '0;
            r_held      <= '0;
            r_prev_err  <= '0;
            r_first     <= 1'b0;
            r_enabled   <= 1'b0;
            r_slew      <= '0;
            r_crossed   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_out_cross <= 1'b0;
                        unique case (in_act)
                            ACT_TICK: begin
                                if (r_enabled) begin
                                    r_err       <= tick_err;
                                    r_meas      <= in_meas;
                                    r_state     <= S_MUL1;
                                end else begin
                                    r_out_cmd <= '0;
                                    r_out_run <= 1'b0;
                                end
                            end
                            ACT_SET: begin
                                r_target   <= in_tgt;
                                r_prev_err <= set_err;
                                r_first    <= 1'b1;
                                r_held     <= '0;
                                r_enabled  <= 1'b1;
                                r_out_cmd  <= r_slew;
                                r_out_run  <= 1'b1;
                            end
                            ACT_STOP: begin
                                r_enabled <= 1'b0;
                                r_slew    <= '0;
                                r_out_cmd <= '0;
                                r_out_run <= 1'b0;
                            end
                            ACT_NONE: begin
                                r_out_cmd <= r_enabled ? r_slew : '0;
                                r_out_run <= r_enabled;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL1: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_drive     <= n_drive;
                    r_crossed   <= add_cross;
                    r_prev_err  <= r_err;
                    r_last_meas <= r_meas;
                    if (add_cross) begin
                        r_held  <= n_drive;
                        r_first <= 1'b0;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_slew      <= n_slew;
                        r_out_cmd   <= n_slew;
                        r_out_cross <= r_crossed;
                        r_out_run   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result stream.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_cmd};
    assign o_m_axis_tuser  = {r_out_run, r_out_cross};

endmodule

// ----- rtl/tbhv_mul.sv -----
// Shared signed multiplier with a registered product.
module tbhv_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [tbhv_pkg::MulAW-1:0]     i_a,
    input  logic signed [tbhv_pkg::MulBW-1:0]     i_b,
    output logic signed [tbhv_pkg::MulPW-1:0]     o_p
);
    import tbhv_pkg::*;

    logic signed [MulPW-1:0] r_p;

    // Product is captured only in the cycles the sequencer asks for it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/tbhv_chk.sv -----
// Port-level checker for the velocity controller, bound to the top level.
module tbhv_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser
);

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // A stopped loop always reports a zero command.
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |-> (o_m_axis_tdata == 8'd0))
        else $error("nonzero command while loop is stopped");

    // A crossing can only be reported by a running loop.
    a_cross_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tuser[1])
        else $error("crossing reported while loop is stopped");

    // A stalled transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind tbh_velocity_control_with_slew_core tbhv_chk u_tbhv_chk (.*);
